FILE: hw/rtl/boost_stump_threshold_search_defines.svh
// Assertion macros shared by the stump search checker.
`ifndef BOOST_STUMP_THRESHOLD_SEARCH_DEFINES_SVH
`define BOOST_STUMP_THRESHOLD_SEARCH_DEFINES_SVH

// checked only outside reset
`define BSTS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BSTS_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bsts_pkg.sv
// Shared widths and register codes for the stump threshold search.
`timescale 1ns / 1ps

package bsts_pkg;

	localparam int IDX_W     = 16;
	localparam int WGT_W     = 32;
	localparam int SUM_W     = 33;
	localparam int ERR_W     = SUM_W + 2;
	localparam int S_TDATA_W = ((IDX_W + WGT_W + 7) / 8) * 8;
	localparam int M_FIELD_W = SUM_W + IDX_W + 1;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int PIPE_DEPTH = 5;

	typedef enum logic [0:0] {
		REG_TOTAL_FACE    = 1'b0,
		REG_TOTAL_NONFACE = 1'b1
	} cfg_reg_t;

endpackage

FILE: hw/rtl/boost_stump_threshold_search.sv
// Top level: decision stump threshold search over one feature's sorted samples.
`timescale 1ns / 1ps

// One sample beat is taken every cycle while the input is not stalled. Its effect passes five
// registers (input register, running sums, error terms, clamped error, best tracking); the result
// register is loaded from the clamped error in parallel with best tracking. The rate is set by the
// two feedback loops: the saturating 33-bit running sum and the 33-bit compare against the best
// error so far. Only the beat marked tlast produces a result beat; input stalls only when such a
// result meets an output register that is still full.
// The user writes totals on the cfg port only while no feature is in flight; it is not enforced.
module boost_stump_threshold_search import bsts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_reg_t             cfg_index,
	input  logic [SUM_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // sample_index[15:0], weight[47:16]
	input  logic                 s_tuser,   // is_face
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // min_error[32:0], best_sample[48:33], polarity[49], zero pad
);

	logic [SUM_W-1:0] tp_q, tn_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic face_s1;
	logic [WGT_W-1:0] wgt_s1;
	logic [SUM_W-1:0] sp_s2, sn_s2;
	logic signed [ERR_W-1:0] left_s3, right_s3;
	logic [SUM_W-1:0] err_s4;
	logic pol_s4;

	logic [SUM_W-1:0] face_sum_q, nonface_sum_q;
	logic [SUM_W-1:0] best_err_q;
	logic [IDX_W-1:0] best_idx_q;
	logic best_pol_q, first_q;

	logic [SUM_W-1:0] out_err_q;
	logic [IDX_W-1:0] out_idx_q;
	logic out_pol_q;

	logic stall, en;
	logic [SUM_W:0] face_add, nonface_add;
	logic [SUM_W-1:0] face_nxt, nonface_nxt;
	logic signed [ERR_W-1:0] left_c, right_c, pick_c;
	logic lt_c;
	logic [SUM_W-1:0] err_c;
	logic take_c;
	logic [SUM_W-1:0] best_err_c;
	logic [IDX_W-1:0] best_idx_c;
	logic best_pol_c;

	assign cfg_ready = 1'b1;
	assign stall     = vld_s4 & last_s4 & m_tvalid & ~m_tready;
	assign en        = ~stall;
	assign s_tready  = en;

	// saturating running sums
	always_comb begin
		face_add    = {1'b0, face_sum_q} + {{(SUM_W + 1 - WGT_W){1'b0}}, wgt_s1};
		nonface_add = {1'b0, nonface_sum_q} + {{(SUM_W + 1 - WGT_W){1'b0}}, wgt_s1};
		face_nxt    = face_sum_q;
		nonface_nxt = nonface_sum_q;
		if (face_s1) begin
			face_nxt = face_add[SUM_W] ? {SUM_W{1'b1}} : face_add[SUM_W-1:0];
		end else begin
			nonface_nxt = nonface_add[SUM_W] ? {SUM_W{1'b1}} : nonface_add[SUM_W-1:0];
		end
	end

	// both error terms, exact and signed
	always_comb begin
		left_c  = $signed({2'b00, sp_s2}) + $signed({2'b00, tn_q}) - $signed({2'b00, sn_s2});
		right_c = $signed({2'b00, sn_s2}) + $signed({2'b00, tp_q}) - $signed({2'b00, sp_s2});
	end

	// polarity and clamp
	always_comb begin
		lt_c   = left_s3 < right_s3;
		pick_c = lt_c ? left_s3 : right_s3;
		if (pick_c[ERR_W-1]) begin
			err_c = '0;
		end else if (|pick_c[ERR_W-2:SUM_W]) begin
			err_c = {SUM_W{1'b1}};
		end else begin
			err_c = pick_c[SUM_W-1:0];
		end
	end

	// first strict minimum
	always_comb begin
		take_c     = first_q | (err_s4 < best_err_q);
		best_err_c = take_c ? err_s4 : best_err_q;
		best_idx_c = take_c ? idx_s4 : best_idx_q;
		best_pol_c = take_c ? pol_s4 : best_pol_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			tn_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOTAL_FACE:    tp_q <= cfg_data;
				REG_TOTAL_NONFACE: tn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_s4        <= 1'b0;
			face_sum_q    <= '0;
			nonface_sum_q <= '0;
			best_err_q    <= '0;
			best_idx_q    <= '0;
			best_pol_q    <= 1'b0;
			first_q       <= 1'b1;
			m_tvalid      <= 1'b0;
		end else begin
			if (en) begin
				vld_s1 <= s_tvalid;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
			end
			if (en && vld_s1) begin
				face_sum_q    <= last_s1 ? '0 : face_nxt;
				nonface_sum_q <= last_s1 ? '0 : nonface_nxt;
			end
			if (en && vld_s4) begin
				if (last_s4) begin
					best_err_q <= '0;
					best_idx_q <= '0;
					best_pol_q <= 1'b0;
					first_q    <= 1'b1;
				end else begin
					best_err_q <= best_err_c;
					best_idx_q <= best_idx_c;
					best_pol_q <= best_pol_c;
					first_q    <= 1'b0;
				end
			end
			if (en && vld_s4 && last_s4) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= s_tdata[IDX_W-1:0];
			wgt_s1   <= s_tdata[IDX_W+WGT_W-1:IDX_W];
			face_s1  <= s_tuser;
			last_s1  <= s_tlast;
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
			sp_s2    <= face_nxt;
			sn_s2    <= nonface_nxt;
			idx_s3   <= idx_s2;
			last_s3  <= last_s2;
			left_s3  <= left_c;
			right_s3 <= right_c;
			idx_s4   <= idx_s3;
			last_s4  <= last_s3;
			err_s4   <= err_c;
			pol_s4   <= ~lt_c;
		end
		if (en && vld_s4 && last_s4) begin
			out_err_q <= best_err_c;
			out_idx_q <= best_idx_c;
			out_pol_q <= best_pol_c;
		end
	end

	assign m_tdata = {{(M_TDATA_W - M_FIELD_W){1'b0}}, out_pol_q, out_idx_q, out_err_q};

endmodule

FILE: hw/rtl/bsts_checker.sv
// Port-level checker for the stump threshold search, bound to the top level.
`timescale 1ns / 1ps
`include "boost_stump_threshold_search_defines.svh"

module bsts_checker import bsts_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tlast,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// last beats taken whose result beat is still owed
	logic [2:0] pend_q;
	logic last_in, res_out;

	assign last_in = s_tvalid & s_tready & s_tlast;
	assign res_out = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b00, last_in} - {2'b00, res_out};
		end
	end

	`BSTS_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
	`BSTS_CHECK(a_out_owed, m_tvalid |-> pend_q != 3'd0, "result beat without a pending last beat")
	`BSTS_CHECK(a_pend_max, pend_q <= 3'(PIPE_DEPTH), "more pending features than pipeline slots")
	`BSTS_CHECK_ALWAYS(a_in_free, !m_tvalid |-> s_tready, "input stalled with empty output register")

endmodule

bind boost_stump_threshold_search bsts_checker u_bsts_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking bench for the stump threshold search: sample streams, totals writes, results.
`timescale 1ns / 1ps

module tb;
	import bsts_pkg::*;

	localparam int ITEM_GOAL = 1700;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [SUM_W-1:0] ONE_FIX = 33'h1_0000_0000;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             is_face;
		logic [WGT_W-1:0] wgt;
		logic             tail;
	} sample_t;

	typedef struct packed {
		logic [SUM_W-1:0] err;
		logic [IDX_W-1:0] idx;
		logic             pol;
	} stump_t;

	class stump_scoreboard;
		logic [SUM_W-1:0] tot_face, tot_nonface;
		logic [SUM_W-1:0] face_acc, nonface_acc, best_err;
		logic [IDX_W-1:0] best_idx;
		logic             best_pol;
		bit               fresh;
		stump_t           best_q[$];
		int               errors;
		int               checked;

		function new();
			tot_face = '0;
			tot_nonface = '0;
			errors = 0;
			checked = 0;
			clear();
		endfunction

		function void clear();
			face_acc = '0;
			nonface_acc = '0;
			best_err = '0;
			best_idx = '0;
			best_pol = 1'b0;
			fresh = 1'b1;
		endfunction

		function void set_total(cfg_reg_t r, logic [SUM_W-1:0] v);
			if (r == REG_TOTAL_FACE)
				tot_face = v;
			else
				tot_nonface = v;
		endfunction

		function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [WGT_W-1:0] w);
			logic [SUM_W:0] s;
			s = {1'b0, acc} + {2'b00, w};
			return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
		endfunction

		function logic [SUM_W-1:0] clamp(logic signed [ERR_W-1:0] v);
			if (v < 0)
				return '0;
			if (v > $signed({2'b00, {SUM_W{1'b1}}}))
				return {SUM_W{1'b1}};
			return v[SUM_W-1:0];
		endfunction

		function void note_sample(sample_t s);
			logic signed [ERR_W-1:0] lhs, rhs;
			logic [SUM_W-1:0]        err;
			logic                    pol;
			stump_t                  res;
			if (s.is_face)
				face_acc = sat_add(face_acc, s.wgt);
			else
				nonface_acc = sat_add(nonface_acc, s.wgt);
			lhs = $signed({2'b00, face_acc}) + $signed({2'b00, tot_nonface})
				- $signed({2'b00, nonface_acc});
			rhs = $signed({2'b00, nonface_acc}) + $signed({2'b00, tot_face})
				- $signed({2'b00, face_acc});
			if (lhs < rhs) begin
				err = clamp(lhs);
				pol = 1'b0;
			end else begin
				err = clamp(rhs);
				pol = 1'b1;
			end
			if (fresh || err < best_err) begin
				best_err = err;
				best_idx = s.idx;
				best_pol = pol;
				fresh = 1'b0;
			end
			if (s.tail) begin
				res.err = best_err;
				res.idx = best_idx;
				res.pol = best_pol;
				best_q.push_back(res);
				clear();
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] d);
			stump_t want, got;
			got.err = d[SUM_W-1:0];
			got.idx = d[SUM_W+IDX_W-1:SUM_W];
			got.pol = d[SUM_W+IDX_W];
			if (best_q.size() == 0) begin
				$display("%0t: unexpected result beat, actual %h", $time, got);
				errors++;
				return;
			end
			want = best_q.pop_front();
			checked++;
			if (got.err !== want.err) begin
				$display("%0t: min_error expected %h actual %h", $time, want.err, got.err);
				errors++;
			end
			if (got.idx !== want.idx) begin
				$display("%0t: best_sample expected %h actual %h", $time, want.idx, got.idx);
				errors++;
			end
			if (got.pol !== want.pol) begin
				$display("%0t: polarity expected %b actual %b", $time, want.pol, got.pol);
				errors++;
			end
		endfunction

		function int pending();
			return best_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index = REG_TOTAL_FACE;
	logic [SUM_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	boost_stump_threshold_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	stump_scoreboard sb = new();
	sample_t         batch[$];
	bit              src_gaps = 1'b0;
	bit              sink_gaps = 1'b0;
	int              items_sent = 0;
	int              cfg_writes = 0;
	int              idle_cycles = 0;
	int              sink_hold = 0;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
			sink_hold = $urandom_range(1, 3) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function void add(logic [IDX_W-1:0] idx, logic face, logic [WGT_W-1:0] w, logic tail);
		sample_t s;
		s.idx = idx;
		s.is_face = face;
		s.wgt = w;
		s.tail = tail;
		batch.push_back(s);
	endfunction

	task automatic play_batch();
		sample_t s;
		while (batch.size() != 0) begin
			s = batch.pop_front();
			if (src_gaps && $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= {s.wgt, s.idx};
			s_tuser <= s.is_face;
			s_tlast <= s.tail;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			sb.note_sample(s);
			items_sent++;
		end
		s_tvalid <= 1'b0;
	endtask

	// wait for every result, then for the pipeline to empty
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [SUM_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_total(r, v);
		cfg_writes++;
	endtask

	task automatic set_totals(logic [SUM_W-1:0] tp, logic [SUM_W-1:0] tn);
		write_reg(REG_TOTAL_FACE, tp);
		write_reg(REG_TOTAL_NONFACE, tn);
		cfg_valid <= 1'b0;
	endtask

	function logic [SUM_W-1:0] pick_total();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ONE_FIX;
			2: return {17'd0, 16'($urandom)};
			3: return {1'b0, 32'($urandom) >> $urandom_range(0, 31)};
			default: return {1'b0, 32'($urandom)};
		endcase
	endfunction

	function logic [WGT_W-1:0] pick_weight(int mode, int len);
		case (mode)
			0: return $urandom_range(0, 32'hFFFF_FFFF / len);
			1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return 32'd1;
					default: return 32'h8000_0000;
				endcase
			end
			default: return 32'($urandom) >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic random_phase();
		int               n_feat, len, wmode, face_bias, mode;
		logic [IDX_W-1:0] base;
		logic [WGT_W-1:0] w;
		logic             face, seq_idx;
		logic [SUM_W:0]   fsum, nsum;
		fsum = '0;
		nsum = '0;
		n_feat = $urandom_range(1, 3);
		for (int f = 0; f < n_feat; f++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			wmode = (f == 0 && $urandom_range(0, 1)) ? 0 : $urandom_range(0, 3);
			face_bias = $urandom_range(1, 9);
			seq_idx = 1'($urandom_range(0, 1));
			base = IDX_W'($urandom);
			for (int k = 0; k < len; k++) begin
				w = pick_weight(wmode, len);
				face = $urandom_range(0, 9) < face_bias;
				add(seq_idx ? base + IDX_W'(k) : IDX_W'($urandom), face, w, k == len - 1);
				if (f == 0) begin
					if (face)
						fsum += w;
					else
						nsum += w;
				end
			end
		end
		mode = $urandom_range(0, 9);
		if (mode < 5) begin
			set_totals((fsum > ONE_FIX) ? ONE_FIX : fsum[SUM_W-1:0],
				(nsum > ONE_FIX) ? ONE_FIX : nsum[SUM_W-1:0]);
		end else if (mode < 8) begin
			set_totals(pick_total(), pick_total());
		end else if (mode == 8) begin
			write_reg($urandom_range(0, 1) ? REG_TOTAL_NONFACE : REG_TOTAL_FACE, pick_total());
			cfg_valid <= 1'b0;
		end
		src_gaps = (items_sent < ITEM_GOAL * 85 / 100) && ($urandom_range(0, 3) != 0);
		sink_gaps = (items_sent < ITEM_GOAL * 85 / 100) && ($urandom_range(0, 3) != 0);
		play_batch();
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// zero totals: tie on a single item, face sum saturation, negative error clamp
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		set_totals('0, '0);
		add(16'h0000, 1'b0, 32'h0000_0000, 1'b1);
		add(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
		add(16'h0001, 1'b1, 32'hFFFF_FFFF, 1'b0);
		add(16'h0002, 1'b1, 32'hFFFF_FFFF, 1'b1);
		play_batch();
		settle();

		// left term smaller, then equal errors that must not replace the first
		set_totals(ONE_FIX, '0);
		add(16'd10, 1'b1, 32'h0000_0100, 1'b0);
		add(16'd11, 1'b0, 32'h0000_0000, 1'b0);
		add(16'd12, 1'b1, 32'h0000_0000, 1'b0);
		add(16'd13, 1'b0, 32'h8000_0000, 1'b1);
		play_batch();
		settle();

		// full totals with non-face saturation
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		set_totals(ONE_FIX, ONE_FIX);
		add(16'd20, 1'b0, 32'hFFFF_FFFF, 1'b0);
		add(16'd21, 1'b0, 32'hFFFF_FFFF, 1'b0);
		add(16'd22, 1'b0, 32'hFFFF_FFFF, 1'b0);
		add(16'd23, 1'b1, 32'hFFFF_FFFF, 1'b0);
		add(16'd24, 1'b1, 32'h0000_0001, 1'b1);
		play_batch();
		settle();

		// consistent totals, back-to-back single-item features
		set_totals(33'h0_8000_0000, 33'h0_8000_0000);
		add(16'd30, 1'b1, 32'h4000_0000, 1'b0);
		add(16'd31, 1'b0, 32'h8000_0000, 1'b0);
		add(16'd32, 1'b1, 32'h4000_0000, 1'b1);
		add(16'd33, 1'b1, 32'h5555_5555, 1'b1);
		add(16'd34, 1'b0, 32'hAAAA_AAAA, 1'b1);
		play_batch();
		settle();

		while (items_sent < ITEM_GOAL)
			random_phase();

		$display("Ran %0d samples through %0d features, %0d totals writes.",
			items_sent, sb.checked, cfg_writes);
		$display("Covered ties, saturation, clamped errors and single-sample features.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
